// File: hw/rtl/tojb_pkg.sv
// ----------------------------------------------------------------------------
// tojb_pkg
// Shared constants, codes and types of the timestamp-ordered jitter buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tojb_pkg;

  localparam int NUM_SLOTS    = 256;
  localparam int BUFFER_DEPTH = 8;
  localparam int SLOTW        = $clog2(NUM_SLOTS);
  localparam int IDXW         = $clog2(BUFFER_DEPTH);
  localparam int CNTW         = $clog2(BUFFER_DEPTH + 1);
  localparam int MS_TO_US     = 1000;
  localparam int DLYW         = 26;
  localparam int FRAC_BITS    = 16;
  localparam int TSW          = 64;
  localparam int SEQW         = 32;
  localparam int PAYW         = 16;
  localparam int GENW         = 32;

  localparam logic [15:0] RENDER_DELAY_RESET = 16'd100;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_RENDER = 2'd1;
  localparam logic [1:0] CMD_COUNT  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_INVALID    = 4'd1;
  localparam logic [3:0] ST_STALE      = 4'd2;
  localparam logic [3:0] ST_DUPLICATE  = 4'd3;
  localparam logic [3:0] ST_TOO_OLD    = 4'd4;
  localparam logic [3:0] ST_EMPTY      = 4'd5;
  localparam logic [3:0] ST_HOLD_FIRST = 4'd6;
  localparam logic [3:0] ST_HOLD_LAST  = 4'd7;
  localparam logic [3:0] ST_BETWEEN    = 4'd8;

  typedef struct packed {
    logic [TSW-1:0]  ts;
    logic [SEQW-1:0] seq;
    logic [PAYW-1:0] pay;
  } entry_t;

  localparam int ENTW = $bits(entry_t);

endpackage

`default_nettype wire

// File: hw/rtl/tojb_ram.sv
// ----------------------------------------------------------------------------
// tojb_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tojb_ram #(
  parameter int AW = 11,
  parameter int DW = 112
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wa,
  input  wire logic [DW-1:0] wd,
  input  wire logic [AW-1:0] ra,
  output logic      [DW-1:0] rd
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

// File: hw/rtl/tojb_meta.sv
// ----------------------------------------------------------------------------
// tojb_meta
// Per-slot generation and count store; slots never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tojb_meta (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [tojb_pkg::SLOTW-1:0] rd_addr,
  output logic      [tojb_pkg::GENW-1:0]  rd_gen,
  output logic      [tojb_pkg::CNTW-1:0]  rd_cnt,
  input  wire logic                      wr_en,
  input  wire logic [tojb_pkg::SLOTW-1:0] wr_addr,
  input  wire logic [tojb_pkg::GENW-1:0]  wr_gen,
  input  wire logic [tojb_pkg::CNTW-1:0]  wr_cnt
);
  import tojb_pkg::*;

  logic [GENW+CNTW-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid;
  logic [GENW+CNTW-1:0] rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_gen, wr_cnt};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_gen = rd_valid ? rd_q[GENW+CNTW-1:CNTW] : '0;
  assign rd_cnt = rd_valid ? rd_q[CNTW-1:0] : '0;

endmodule

`default_nettype wire

// File: hw/rtl/tojb_frac.sv
// ----------------------------------------------------------------------------
// tojb_frac
// Serial restoring divider: floor(num * 2^16 / den), num below den.
// ----------------------------------------------------------------------------
`default_nettype none

module tojb_frac (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tojb_pkg::TSW-1:0]       num,
  input  wire logic [tojb_pkg::TSW-1:0]       den,
  output logic                               done,
  output logic      [tojb_pkg::FRAC_BITS-1:0] q
);
  import tojb_pkg::*;

  localparam int STEPW = $clog2(FRAC_BITS);

  logic [TSW-1:0]   r;
  logic [TSW-1:0]   d;
  logic [STEPW-1:0] step;
  logic             run;
  logic [TSW:0]     diff;

  // 2r - den: non-negative means r >= den - r
  assign diff = {r, 1'b0} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r    <= num;
        d    <= den;
        q    <= '0;
        step <= '0;
        run  <= 1'b1;
      end else if (run) begin
        q    <= {q[FRAC_BITS-2:0], ~diff[TSW]};
        r    <= diff[TSW] ? {r[TSW-2:0], 1'b0} : diff[TSW-1:0];
        step <= step + 1'b1;
        if (step == STEPW'(FRAC_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/timestamp_ordered_jitter_buffer.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_jitter_buffer
// Per-slot sorted state lists with insert, render/prune, count and no-op commands.
// ----------------------------------------------------------------------------
// Usage: drive a command and its fields with start while busy is low; the
// beat is taken on that edge and busy stays high until the result is out.
// The result is shown for one cycle with done; the receiver cannot stall,
// so a result is lost if it is not taken in that cycle.
// render_delay_we loads render_delay_ms; write it only while idle.
// Steps: count, no-op, invalid, stale and empty commands go from S_META
// straight to S_FIN. Insert reads each stored entry for the duplicate scan,
// moves each entry down on eviction and shifts each entry passed up in the
// sorted insertion. Render reads each entry scanned, runs the fraction
// divider when between, and moves each remaining entry in the prune pass.
// All entry moves go through the single entry RAM port pair, each entry read
// then written; the fraction comes from a one-bit-per-cycle divider.
// Reset: all slots read as empty with generation 0, delay is 100 ms. No
// clearing pass is needed; the entry RAM is read only below a slot's count.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_ordered_jitter_buffer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        render_delay_we,
  input  wire logic [15:0] render_delay_ms,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  slot_index,
  input  wire logic        entity_valid,
  input  wire logic [31:0] generation,
  input  wire logic [63:0] timestamp,
  input  wire logic [31:0] sequence_req,
  input  wire logic [15:0] payload_ref,
  input  wire logic [63:0] current_time,
  output logic             done,
  output logic [3:0]       status,
  output logic [15:0]      lower_payload,
  output logic [15:0]      upper_payload,
  output logic [15:0]      blend_fraction,
  output logic [3:0]       stored_count
);
  import tojb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_META, S_RT, S_DUP_RD, S_DUP_CHK, S_SH_RD, S_SH_WR,
    S_INS_RD, S_INS_CHK, S_INS_PUT, S_RS_RD, S_RS_CHK, S_DIV, S_FIN
  } state_t;

  state_t state;

  logic [15:0]      delay_ms;
  logic [DLYW-1:0]  delay_usec;
  logic [1:0]       cmd_q;
  logic             oob_q;
  logic [SLOTW-1:0] slot_q;
  logic             ev_q;
  logic [GENW-1:0]  gen_q;
  logic [TSW-1:0]   key_t;
  logic [SEQW-1:0]  seq_q;
  logic [PAYW-1:0]  pay_q;
  logic [TSW-1:0]   cur_q;
  logic [GENW-1:0]  mgen;
  logic             wr_meta;
  logic [CNTW-1:0]  wc;
  logic [CNTW-1:0]  i;
  logic [IDXW-1:0]  sh_n;
  logic             sh_ins;
  logic             old0;
  logic [TSW-1:0]   prev_t;
  logic [PAYW-1:0]  prev_pay;
  logic [3:0]       res_status;
  logic [PAYW-1:0]  res_lo;
  logic [PAYW-1:0]  res_up;
  logic [FRAC_BITS-1:0] res_fr;
  logic [CNTW-1:0]  res_cnt;

  logic [GENW-1:0]  mrd_gen;
  logic [CNTW-1:0]  mrd_cnt;
  entry_t           ent_rd;
  entry_t           ent_wd;
  entry_t           ent_new;
  logic             ent_we;
  logic [IDXW-1:0]  ent_widx;
  logic             div_start;
  logic             div_done;
  logic [FRAC_BITS-1:0] div_q;
  logic             acc;
  logic             t_lt, t_eq, lt, eq;
  logic             old_now;
  logic [CNTW-1:0]  wc_n;

  assign busy = (state != S_IDLE);
  assign acc  = start && !busy;

  // shared key comparator against the entry just read
  assign t_lt = key_t < ent_rd.ts;
  assign t_eq = key_t == ent_rd.ts;
  assign lt   = t_lt || (t_eq && (seq_q < ent_rd.seq));
  assign eq   = t_eq && (seq_q == ent_rd.seq);

  assign ent_new = '{ts: key_t, seq: seq_q, pay: pay_q};
  assign old_now = (i == '0) ? lt : old0;
  assign wc_n    = (mrd_cnt != '0 && gen_q > mrd_gen) ? '0 : mrd_cnt;

  always_comb begin
    ent_we   = 1'b0;
    ent_widx = i[IDXW-1:0];
    ent_wd   = ent_new;
    unique case (state)
      S_SH_WR: begin
        ent_we   = 1'b1;
        ent_widx = IDXW'(i - CNTW'(sh_n));
        ent_wd   = ent_rd;
      end
      S_INS_CHK: begin
        ent_we   = 1'b1;
        ent_widx = IDXW'(i + 1'b1);
        ent_wd   = lt ? ent_rd : ent_new;
      end
      S_INS_PUT: begin
        ent_we   = 1'b1;
        ent_widx = '0;
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
  end

  assign div_start = (state == S_RS_CHK) && t_lt && (i != '0);

  tojb_ram #(
    .AW(SLOTW + IDXW),
    .DW(ENTW)
  ) u_ent (
    .clk(clk),
    .we (ent_we),
    .wa ({slot_q, ent_widx}),
    .wd (ent_wd),
    .ra ({slot_q, i[IDXW-1:0]}),
    .rd (ent_rd)
  );

  tojb_meta u_meta (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (acc),
    .rd_addr(SLOTW'(slot_index)),
    .rd_gen (mrd_gen),
    .rd_cnt (mrd_cnt),
    .wr_en  (state == S_FIN && wr_meta),
    .wr_addr(slot_q),
    .wr_gen (mgen),
    .wr_cnt (res_cnt)
  );

  tojb_frac u_frac (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (key_t - prev_t),
    .den  (ent_rd.ts - prev_t),
    .done (div_done),
    .q    (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms <= RENDER_DELAY_RESET;
    end else if (render_delay_we) begin
      delay_ms <= render_delay_ms;
    end
    delay_usec <= DLYW'(delay_ms) * DLYW'(MS_TO_US);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      wr_meta <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd;
            oob_q   <= 32'(slot_index) >= NUM_SLOTS;
            slot_q  <= SLOTW'(slot_index);
            ev_q    <= entity_valid;
            gen_q   <= generation;
            key_t   <= timestamp;
            seq_q   <= sequence_req;
            pay_q   <= payload_ref;
            cur_q   <= current_time;
            wr_meta <= 1'b0;
            res_lo  <= '0;
            res_up  <= '0;
            res_fr  <= '0;
            state   <= S_META;
          end
        end
        S_META: begin
          i <= '0;
          if (cmd_q == CMD_NONE) begin
            res_status <= ST_OK;
            res_cnt    <= '0;
            state      <= S_FIN;
          end else if (oob_q) begin
            res_status <= ST_INVALID;
            res_cnt    <= '0;
            state      <= S_FIN;
          end else if (cmd_q == CMD_COUNT) begin
            res_status <= ST_OK;
            res_cnt    <= (mrd_gen == gen_q) ? mrd_cnt : '0;
            state      <= S_FIN;
          end else if (cmd_q == CMD_INSERT) begin
            if (!ev_q) begin
              res_status <= ST_INVALID;
              res_cnt    <= mrd_cnt;
              state      <= S_FIN;
            end else if (mrd_cnt != '0 && gen_q < mrd_gen) begin
              res_status <= ST_STALE;
              res_cnt    <= mrd_cnt;
              state      <= S_FIN;
            end else begin
              wc      <= wc_n;
              wr_meta <= 1'b1;
              mgen    <= gen_q;
              res_cnt <= wc_n;
              old0    <= 1'b0;
              state   <= (wc_n == '0) ? S_INS_PUT : S_DUP_RD;
            end
          end else begin
            mgen <= mrd_gen;
            wc   <= mrd_cnt;
            if (mrd_cnt == '0) begin
              res_status <= ST_EMPTY;
              res_cnt    <= '0;
              state      <= S_FIN;
            end else begin
              wr_meta <= 1'b1;
              state   <= S_RT;
            end
          end
        end
        S_RT: begin
          key_t <= (cur_q > TSW'(delay_usec)) ? cur_q - TSW'(delay_usec) : '0;
          state <= S_RS_RD;
        end
        S_DUP_RD: begin
          state <= S_DUP_CHK;
        end
        S_DUP_CHK: begin
          if (i == '0) begin
            old0 <= lt;
          end
          if (eq) begin
            res_status <= ST_DUPLICATE;
            res_cnt    <= wc;
            state      <= S_FIN;
          end else if (i == wc - 1'b1) begin
            if (wc == CNTW'(BUFFER_DEPTH)) begin
              if (old_now) begin
                res_status <= ST_TOO_OLD;
                res_cnt    <= wc;
                state      <= S_FIN;
              end else begin
                // evict the front, then insert
                sh_n   <= IDXW'(1);
                sh_ins <= 1'b1;
                i      <= CNTW'(1);
                state  <= S_SH_RD;
              end
            end else begin
              state <= S_INS_RD;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_DUP_RD;
          end
        end
        S_SH_RD: begin
          if (i == wc) begin
            wc <= wc - CNTW'(sh_n);
            if (sh_ins) begin
              i     <= wc - CNTW'(sh_n) - 1'b1;
              state <= S_INS_RD;
            end else begin
              res_cnt <= wc - CNTW'(sh_n);
              state   <= S_FIN;
            end
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          i     <= i + 1'b1;
          state <= S_SH_RD;
        end
        S_INS_RD: begin
          state <= S_INS_CHK;
        end
        S_INS_CHK: begin
          if (lt) begin
            if (i == '0) begin
              state <= S_INS_PUT;
            end else begin
              i     <= i - 1'b1;
              state <= S_INS_RD;
            end
          end else begin
            res_status <= ST_OK;
            res_cnt    <= wc + 1'b1;
            state      <= S_FIN;
          end
        end
        S_INS_PUT: begin
          res_status <= ST_OK;
          res_cnt    <= wc + 1'b1;
          state      <= S_FIN;
        end
        S_RS_RD: begin
          state <= S_RS_CHK;
        end
        S_RS_CHK: begin
          if (t_lt) begin
            if (i == '0) begin
              res_status <= ST_HOLD_FIRST;
              res_lo     <= ent_rd.pay;
              res_cnt    <= wc;
              state      <= S_FIN;
            end else begin
              res_status <= ST_BETWEEN;
              res_lo     <= prev_pay;
              res_up     <= ent_rd.pay;
              sh_n       <= IDXW'(i - 1'b1);
              sh_ins     <= 1'b0;
              i          <= i - 1'b1;
              state      <= S_DIV;
            end
          end else begin
            prev_t   <= ent_rd.ts;
            prev_pay <= ent_rd.pay;
            if (i == wc - 1'b1) begin
              res_status <= ST_HOLD_LAST;
              res_lo     <= ent_rd.pay;
              sh_n       <= IDXW'(i);
              sh_ins     <= 1'b0;
              state      <= S_SH_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_RS_RD;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_fr <= div_q;
            state  <= S_SH_RD;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status         = res_status;
  assign lower_payload  = res_lo;
  assign upper_payload  = res_up;
  assign blend_fraction = res_fr;
  assign stored_count   = 4'(res_cnt);

endmodule

`default_nettype wire

// File: hw/rtl/tojb_checker.sv
// ----------------------------------------------------------------------------
// tojb_checker
// Port-level checks of the command handshake and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tojb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [3:0] status
);
  import tojb_pkg::*;

  // a taken command keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted command");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result beats in a row");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_BETWEEN)
    else $error("status code out of range");

endmodule

bind timestamp_ordered_jitter_buffer tojb_checker u_tojb_checker (.*);

`default_nettype wire

// File: tb/tb_timestamp_ordered_jitter_buffer.sv
// ----------------------------------------------------------------------------
// tb_timestamp_ordered_jitter_buffer
// Self-checking bench: random and directed insert/render/count commands
// against a behavioral model of the per-slot sorted lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timestamp_ordered_jitter_buffer;
  import tojb_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  idx;
    logic        vld;
    logic [31:0] gen;
    logic [63:0] ts;
    logic [31:0] seq;
    logic [15:0] pay;
    logic [63:0] now;
  } cmd_beat_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] lo;
    logic [15:0] up;
    logic [15:0] frac;
    logic [3:0]  cnt;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic dly_we = 1'b0;
  logic [15:0] dly_val = 16'd0;
  cmd_beat_t drv = '0;
  logic [3:0]  status, stored_count;
  logic [15:0] lower_payload, upper_payload, blend_fraction;

  timestamp_ordered_jitter_buffer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .render_delay_we(dly_we), .render_delay_ms(dly_val),
    .cmd(drv.cmd), .slot_index(drv.idx), .entity_valid(drv.vld),
    .generation(drv.gen), .timestamp(drv.ts), .sequence_req(drv.seq),
    .payload_ref(drv.pay), .current_time(drv.now),
    .done(done), .status(status), .lower_payload(lower_payload),
    .upper_payload(upper_payload), .blend_fraction(blend_fraction),
    .stored_count(stored_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  logic [15:0] m_delay;
  logic [31:0] m_gen [NUM_SLOTS];
  int          m_cnt [NUM_SLOTS];
  logic [63:0] m_ts  [NUM_SLOTS][BUFFER_DEPTH];
  logic [31:0] m_seq [NUM_SLOTS][BUFFER_DEPTH];
  logic [15:0] m_pay [NUM_SLOTS][BUFFER_DEPTH];

  cmd_beat_t pending_cmds[$];
  reply_t    expected_replies[$];
  int errors = 0;
  int n_sent = 0, n_seen = 0;
  int st_hits [16];

  function automatic logic [15:0] q16_fraction(logic [63:0] num, logic [63:0] den);
    logic [63:0] r, t;
    logic [15:0] q;
    r = num;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      t = den - r;
      q = q << 1;
      if (r >= t) begin
        q[0] = 1'b1;
        r = r - t;
      end else begin
        r = r + r;
      end
    end
    return q;
  endfunction

  function automatic void drop_oldest(int s, int n);
    for (int i = n; i < m_cnt[s]; i++) begin
      m_ts[s][i-n] = m_ts[s][i];
      m_seq[s][i-n] = m_seq[s][i];
      m_pay[s][i-n] = m_pay[s][i];
    end
    m_cnt[s] -= n;
  endfunction

  function automatic logic [3:0] model_insert(int s, cmd_beat_t c);
    int pos;
    if (m_cnt[s] != 0 && c.gen > m_gen[s]) m_cnt[s] = 0;
    else if (m_cnt[s] != 0 && c.gen < m_gen[s]) return ST_STALE;
    m_gen[s] = c.gen;
    for (int i = 0; i < m_cnt[s]; i++)
      if (m_seq[s][i] == c.seq && m_ts[s][i] == c.ts) return ST_DUPLICATE;
    if (m_cnt[s] >= BUFFER_DEPTH) begin
      if (c.ts < m_ts[s][0] || (c.ts == m_ts[s][0] && c.seq < m_seq[s][0]))
        return ST_TOO_OLD;
      drop_oldest(s, 1);
    end
    pos = m_cnt[s];
    for (int i = 0; i < m_cnt[s]; i++)
      if (c.ts < m_ts[s][i] || (c.ts == m_ts[s][i] && c.seq < m_seq[s][i])) begin
        pos = i;
        break;
      end
    for (int i = m_cnt[s]; i > pos; i--) begin
      m_ts[s][i] = m_ts[s][i-1];
      m_seq[s][i] = m_seq[s][i-1];
      m_pay[s][i] = m_pay[s][i-1];
    end
    m_ts[s][pos] = c.ts;
    m_seq[s][pos] = c.seq;
    m_pay[s][pos] = c.pay;
    m_cnt[s]++;
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(cmd_beat_t c);
    reply_t r;
    int s, u;
    logic [63:0] dly, rt;
    r = '0;
    s = int'(c.idx);
    if (c.cmd == CMD_NONE) return r;
    if (c.cmd == CMD_INSERT) begin
      r.status = c.vld ? model_insert(s, c) : ST_INVALID;
      r.cnt = 4'(m_cnt[s]);
    end else if (c.cmd == CMD_COUNT) begin
      r.status = ST_OK;
      r.cnt = (m_gen[s] == c.gen) ? 4'(m_cnt[s]) : 4'd0;
    end else if (m_cnt[s] == 0) begin
      r.status = ST_EMPTY;
    end else begin
      dly = 64'(m_delay) * 64'd1000;
      rt = (c.now > dly) ? c.now - dly : 64'd0;
      u = m_cnt[s];
      for (int i = 0; i < m_cnt[s]; i++)
        if (m_ts[s][i] > rt) begin
          u = i;
          break;
        end
      if (u == 0) begin
        r.status = ST_HOLD_FIRST;
        r.lo = m_pay[s][0];
      end else if (u == m_cnt[s]) begin
        r.status = ST_HOLD_LAST;
        r.lo = m_pay[s][u-1];
      end else begin
        r.status = ST_BETWEEN;
        r.lo = m_pay[s][u-1];
        r.up = m_pay[s][u];
        r.frac = q16_fraction(rt - m_ts[s][u-1], m_ts[s][u] - m_ts[s][u-1]);
      end
      if (u != 0) drop_oldest(s, u - 1);
      r.cnt = 4'(m_cnt[s]);
    end
    return r;
  endfunction

  // driver: one beat per command, random gap before each
  int gap = 0;
  logic took = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (start && took) begin
        start <= 1'b0;
        gap <= $urandom_range(0, 12);
      end else if (!start && pending_cmds.size() != 0) begin
        if (gap > 0) gap <= gap - 1;
        else begin
          drv <= pending_cmds.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // acceptance and monitor at rising edge
  reply_t got, exp_r;
  always @(posedge clk) begin
    took <= 1'b0;
    if (!rst && start && !busy) begin
      expected_replies.push_back(predict_reply(drv));
      took <= 1'b1;
      n_sent++;
    end
    if (!rst && done) begin
      got = '{status, lower_payload, upper_payload, blend_fraction, stored_count};
      n_seen++;
      if (expected_replies.size() == 0) begin
        $error("reply with nothing expected: status %0d", got.status);
        errors++;
      end else begin
        exp_r = expected_replies.pop_front();
        st_hits[exp_r.status]++;
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.lo !== exp_r.lo) begin
          $error("lower_payload exp %h got %h", exp_r.lo, got.lo); errors++;
        end
        if (got.up !== exp_r.up) begin
          $error("upper_payload exp %h got %h", exp_r.up, got.up); errors++;
        end
        if (got.frac !== exp_r.frac) begin
          $error("blend_fraction exp %h got %h", exp_r.frac, got.frac); errors++;
        end
        if (got.cnt !== exp_r.cnt) begin
          $error("stored_count exp %0d got %0d", exp_r.cnt, got.cnt); errors++;
        end
      end
    end
  end

  // stimulus helpers
  logic [31:0] t_gen [4];
  logic [63:0] t_now [4];

  function automatic cmd_beat_t mk(logic [1:0] c, logic [7:0] idx, logic [31:0] gen,
                                   logic [63:0] ts, logic [31:0] seq, logic [63:0] now);
    cmd_beat_t b;
    b.cmd = c; b.idx = idx; b.vld = 1'b1; b.gen = gen; b.ts = ts; b.seq = seq;
    b.pay = 16'($urandom); b.now = now;
    return b;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start);
    @(posedge clk);
    wait (expected_replies.size() == 0 && !busy);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_delay(logic [15:0] v);
    @(negedge clk);
    dly_we <= 1'b1;
    dly_val <= v;
    @(negedge clk);
    dly_we <= 1'b0;
    m_delay = v;
  endtask

  // mostly well-formed traffic on a few hot slots; ts near a moving clock
  task automatic random_phase(int n);
    cmd_beat_t b;
    int k, sl;
    for (int i = 0; i < n; i++) begin
      sl = $urandom_range(0, 3);
      k = $urandom_range(0, 99);
      t_now[sl] += $urandom_range(0, 40000);
      if (k < 55) begin
        b = mk(CMD_INSERT, 8'(sl * 61), t_gen[sl],
               t_now[sl] + $urandom_range(0, 300000) - 150000,
               $urandom_range(0, 3), 0);
        if ($urandom_range(0, 19) == 0) b.gen = t_gen[sl] + 1;
        if ($urandom_range(0, 19) == 0) b.gen = t_gen[sl] - 1;
        if ($urandom_range(0, 29) == 0) b.vld = 1'b0;
        if (b.gen > t_gen[sl]) t_gen[sl] = b.gen;
      end else if (k < 80) begin
        b = mk(CMD_RENDER, 8'(sl * 61), 0, 0, 0, t_now[sl] + $urandom_range(0, 150000));
      end else if (k < 90) begin
        b = mk(CMD_COUNT, 8'(sl * 61), t_gen[sl] - $urandom_range(0, 1), 0, 0, 0);
      end else begin
        // noise: full-width random fields, any command
        b.cmd = 2'($urandom);
        b.idx = 8'($urandom);
        b.vld = 1'($urandom);
        b.gen = $urandom;
        b.ts  = {$urandom, $urandom};
        b.seq = $urandom;
        b.pay = 16'($urandom);
        b.now = {$urandom, $urandom};
      end
      pending_cmds.push_back(b);
    end
  endtask

  initial begin
    m_delay = RENDER_DELAY_RESET;
    foreach (m_gen[s]) begin
      m_gen[s] = '0;
      m_cnt[s] = 0;
    end
    foreach (st_hits[i]) st_hits[i] = 0;
    foreach (t_gen[i]) begin
      t_gen[i] = $urandom_range(1, 5);
      t_now[i] = 64'd1000000;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty render, fills, overflow, duplicates, stale, extremes
    pending_cmds.push_back(mk(CMD_RENDER, 8'd7, 0, 0, 0, 64'd5));
    pending_cmds.push_back(mk(CMD_INSERT, 8'd7, 32'd3, 64'd1000, 1, 0));
    pending_cmds.push_back(mk(CMD_INSERT, 8'd7, 32'd3, 64'd1000, 1, 0));
    pending_cmds.push_back(mk(CMD_INSERT, 8'd7, 32'd2, 64'd2000, 1, 0));
    pending_cmds.push_back(mk(CMD_INSERT, 8'd7, 32'd3, 64'd1000, 0, 0));
    for (int i = 0; i < 8; i++)
      pending_cmds.push_back(mk(CMD_INSERT, 8'd7, 32'd3, 64'd200000 + 64'(i) * 50000, 9, 0));
    pending_cmds.push_back(mk(CMD_INSERT, 8'd7, 32'd3, 64'd0, 0, 0));
    pending_cmds.push_back(mk(CMD_COUNT, 8'd7, 32'd3, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_COUNT, 8'd7, 32'd4, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_RENDER, 8'd7, 0, 0, 0, 64'd0));
    pending_cmds.push_back(mk(CMD_RENDER, 8'd7, 0, 0, 0, 64'd412345));
    pending_cmds.push_back(mk(CMD_RENDER, 8'd7, 0, 0, 0, '1));
    pending_cmds.push_back(mk(CMD_INSERT, 8'd7, 32'hFFFF_FFFF, '1, '1, 0));
    pending_cmds.push_back(mk(CMD_INSERT, 8'd255, 32'd0, 64'd0, 0, 0));
    pending_cmds.push_back(mk(CMD_NONE, 8'd255, '1, '1, '1, '1));
    pending_cmds[$].pay = 16'hFFFF;
    pending_cmds.push_back(mk(CMD_INSERT, 8'd9, 32'd1, 64'd5, 0, 0));
    pending_cmds[$].vld = 1'b0;
    drain();

    write_delay(16'd0);
    random_phase(500);
    drain();   // sender holds off until every reply has come
    write_delay(16'hFFFF);
    random_phase(150);
    drain();
    write_delay(16'd20);
    random_phase(500);
    drain();
    write_delay(16'd100);
    random_phase(480);
    drain();

    $display("Ran %0d commands, %0d replies: between %0d, hold %0d/%0d, too old %0d.",
             n_sent, n_seen, st_hits[ST_BETWEEN], st_hits[ST_HOLD_FIRST],
             st_hits[ST_HOLD_LAST], st_hits[ST_TOO_OLD]);
    $display("Stale %0d, duplicate %0d, empty %0d, invalid %0d.", st_hits[ST_STALE],
             st_hits[ST_DUPLICATE], st_hits[ST_EMPTY], st_hits[ST_INVALID]);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
